### hw/rtl/swizzled_rect_pixel_transfer_core_defines.svh
// Assertion macros for the swizzled rectangle pixel transfer core.
`ifndef SWIZZLED_RECT_PIXEL_TRANSFER_CORE_DEFINES_SVH
`define SWIZZLED_RECT_PIXEL_TRANSFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SRPT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srpt check failed");
`define SRPT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srpt check failed");
`else
`define SRPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRPT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/srpt_pkg.sv
// Types, constants and swizzle tables shared by the pixel transfer core.
package srpt_pkg;

  localparam int ADDR_BITS   = 20;
  localparam int DATA_W      = 32;
  localparam int WORD_ADDR_W = 20;
  localparam int CUR_W       = 12;
  localparam int COORD_W     = 13;
  localparam int SUM_W       = 28;
  localparam int CFG_W       = 22;
  localparam int IDX_W       = 3;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2
  } srpt_op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_BLOCK   = 3'd0,
    REG_BUFFER_WIDTH = 3'd1,
    REG_START_X      = 3'd2,
    REG_START_Y      = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_BYTE_OFFSET  = 3'd6
  } srpt_reg_t;

  typedef struct packed {
    logic [13:0] base_block;
    logic [5:0]  buffer_width;
    logic [10:0] start_x;
    logic [10:0] start_y;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    logic [21:0] byte_offset;
  } srpt_cfg_t;

  // Pixel position stage: what to do and where in the frame.
  typedef struct packed {
    logic               access;
    logic               wr;
    logic               last;
    logic               status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DATA_W-1:0]  wdata;
  } srpt_pix_t;

  // Memory access stage: swizzled word address.
  typedef struct packed {
    logic                 access;
    logic                 wr;
    logic                 last;
    logic                 status;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_W-1:0]    wdata;
  } srpt_acc_t;

  localparam logic [4:0] BLOCK_ORDER [32] = '{
    5'd0,  5'd1,  5'd4,  5'd5,  5'd16, 5'd17, 5'd20, 5'd21,
    5'd2,  5'd3,  5'd6,  5'd7,  5'd18, 5'd19, 5'd22, 5'd23,
    5'd8,  5'd9,  5'd12, 5'd13, 5'd24, 5'd25, 5'd28, 5'd29,
    5'd10, 5'd11, 5'd14, 5'd15, 5'd26, 5'd27, 5'd30, 5'd31
  };

  localparam logic [3:0] COLUMN_WORD [16] = '{
    4'd0, 4'd1, 4'd4, 4'd5, 4'd8,  4'd9,  4'd12, 4'd13,
    4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15
  };

endpackage

### hw/rtl/srpt_if.sv
// Valid/ready channel interfaces for pixel items and result beats.
interface srpt_in_if
  import srpt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output opcode, output write_data, input ready);
  modport sink (input valid, input opcode, input write_data, output ready);
endinterface

interface srpt_out_if
  import srpt_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [DATA_W-1:0]      read_data;
  logic [WORD_ADDR_W-1:0] word_address;
  logic                   last_pixel;
  logic                   status;

  modport source (output valid, output read_data, output word_address,
                  output last_pixel, output status, input ready);
  modport sink (input valid, input read_data, input word_address,
                input last_pixel, input status, output ready);
endinterface

### hw/rtl/srpt_ram.sv
// Single-port synchronous RAM with registered read data.
module srpt_ram #(
  parameter int ADDR_W = 20,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hw/rtl/srpt_cursor.sv
// Cursor walk over the rectangle and per-item decision, first pipeline stage.
module srpt_cursor
  import srpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              advance,
  input  logic [1:0]        opcode,
  input  logic [DATA_W-1:0] write_data,
  input  srpt_cfg_t         cfg,
  output logic              s1_valid,
  output srpt_pix_t         s1_pix
);

  logic [CUR_W-1:0] cursor_col, cursor_col_next;
  logic [CUR_W-1:0] cursor_row, cursor_row_next;
  logic             transfer_done, transfer_done_next;
  logic [CUR_W:0]   col_inc, row_inc;
  logic             col_wrap, row_wrap;
  srpt_pix_t        pix;

  assign col_inc  = {1'b0, cursor_col} + 13'd1;
  assign row_inc  = {1'b0, cursor_row} + 13'd1;
  assign col_wrap = col_inc >= {1'b0, cfg.rect_width};
  assign row_wrap = row_inc >= {1'b0, cfg.rect_height};

  always_comb begin
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    transfer_done_next = transfer_done;
    pix.access = 1'b0;
    pix.wr     = opcode == OP_WRITE;
    pix.last   = 1'b0;
    pix.status = 1'b0;
    pix.x      = COORD_W'({2'b00, cfg.start_x}) + COORD_W'({1'b0, cursor_col});
    pix.y      = COORD_W'({2'b00, cfg.start_y}) + COORD_W'({1'b0, cursor_row});
    pix.wdata  = write_data;
    unique case (srpt_op_t'(opcode)) inside
      OP_RESTART: begin
        cursor_col_next    = '0;
        cursor_row_next    = '0;
        transfer_done_next = 1'b0;
      end
      OP_WRITE, OP_READ: begin
        if (transfer_done || cfg.rect_width == '0 || cfg.rect_height == '0) begin
          pix.status = 1'b1;
        end else if (cursor_row >= cfg.rect_height) begin
          pix.status         = 1'b1;
          transfer_done_next = 1'b1;
        end else begin
          pix.access = 1'b1;
          if (col_wrap) begin
            cursor_col_next = '0;
            if (row_wrap) begin
              cursor_row_next    = '0;
              transfer_done_next = 1'b1;
              pix.last           = 1'b1;
            end else begin
              cursor_row_next = row_inc[CUR_W-1:0];
            end
          end else begin
            cursor_col_next = col_inc[CUR_W-1:0];
          end
        end
      end
      default: begin
        pix.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col    <= '0;
      cursor_row    <= '0;
      transfer_done <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        cursor_col    <= cursor_col_next;
        cursor_row    <= cursor_row_next;
        transfer_done <= transfer_done_next;
      end
      if (advance) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix;
    end
  end

endmodule

### hw/rtl/srpt_swizzle.sv
// Page, block and column swizzle of the pixel position into a word address.
module srpt_swizzle
  import srpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      s1_valid,
  input  srpt_pix_t s1_pix,
  input  srpt_cfg_t cfg,
  output logic      s2_valid,
  output srpt_acc_t s2_acc
);

  logic [13:0]      page_row;
  logic [14:0]      page;
  logic [4:0]       blk;
  logic [3:0]       cw;
  logic [SUM_W-1:0] sum;
  srpt_acc_t        acc;

  assign page_row = 14'(s1_pix.y[12:5]) * 14'(cfg.buffer_width);
  assign page     = 15'(s1_pix.x[12:6]) + 15'(page_row);
  assign blk      = BLOCK_ORDER[{s1_pix.y[4:3], s1_pix.x[5:3]}];
  assign cw       = COLUMN_WORD[{s1_pix.y[0], s1_pix.x[2:0]}];

  assign sum = (SUM_W'(cfg.base_block) << 6) + (SUM_W'(page) << 11)
             + (SUM_W'(blk) << 6) + (SUM_W'(s1_pix.y[2:1]) << 4)
             + SUM_W'(cw) + SUM_W'(cfg.byte_offset[21:2]);

  always_comb begin
    acc.access = s1_pix.access;
    acc.wr     = s1_pix.wr;
    acc.last   = s1_pix.last;
    acc.status = s1_pix.status;
    acc.addr   = s1_pix.access ? sum[ADDR_BITS-1:0] : '0;
    acc.wdata  = s1_pix.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_acc <= acc;
    end
  end

endmodule

### hw/rtl/swizzled_rect_pixel_transfer_core.sv
// Top level of the swizzled rectangle pixel transfer core.
//
// Pixel items enter on pix_in (opcode, write_data) and one result beat per
// item leaves on pix_out (read_data, word_address, last_pixel, status).
// Opcodes: restart the cursor, write the next pixel, read the next pixel.
// The cursor walks the configured rectangle row by row; each pixel maps to a
// word of a 2^ADDR_BITS x 32 local memory in 64x32 page, 8x8 block, 8x2
// column layout. Configuration goes in through cfg_write_en, cfg_index and
// cfg_write_data; the user must write it only while no item is in flight,
// and the core does not enforce this. A result beat passes the registered
// cursor stage, address stage and memory read stage in that order.
// Throughput: one item per cycle while pix_out is ready, set by the single
// memory port that serves one access per beat.
// Reset clears the cursor, the done flag and the pipeline valids and loads
// the register defaults; memory contents are undefined until written, and
// no clearing pass runs. When pix_out stalls, the output beat holds and the
// upstream stages keep filling until all three are occupied, then pix_in
// drops ready.
`include "swizzled_rect_pixel_transfer_core_defines.svh"

module swizzled_rect_pixel_transfer_core
  import srpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_write_data,
  srpt_in_if.sink          pix_in,
  srpt_out_if.source       pix_out
);

  srpt_cfg_t            cfg;
  logic                 adv1, adv2, adv3;
  logic                 accept;
  logic                 s1_valid, s2_valid, s3_valid;
  srpt_pix_t            s1_pix;
  srpt_acc_t            s2_acc;
  logic                 s3_read, s3_last, s3_status;
  logic [ADDR_BITS-1:0] s3_addr;
  logic                 ram_we, ram_re;
  logic [DATA_W-1:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_block   <= '0;
      cfg.buffer_width <= 6'd1;
      cfg.start_x      <= '0;
      cfg.start_y      <= '0;
      cfg.rect_width   <= '0;
      cfg.rect_height  <= '0;
      cfg.byte_offset  <= '0;
    end else if (cfg_write_en) begin
      unique case (srpt_reg_t'(cfg_index))
        REG_BASE_BLOCK:   cfg.base_block   <= cfg_write_data[13:0];
        REG_BUFFER_WIDTH: cfg.buffer_width <= cfg_write_data[5:0];
        REG_START_X:      cfg.start_x      <= cfg_write_data[10:0];
        REG_START_Y:      cfg.start_y      <= cfg_write_data[10:0];
        REG_RECT_WIDTH:   cfg.rect_width   <= cfg_write_data[11:0];
        REG_RECT_HEIGHT:  cfg.rect_height  <= cfg_write_data[11:0];
        REG_BYTE_OFFSET:  cfg.byte_offset  <= cfg_write_data;
        default: ;
      endcase
    end
  end

  // each stage moves when it is empty or the one after it moves
  assign adv3 = !s3_valid || pix_out.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign pix_in.ready = adv1;
  assign accept       = pix_in.valid && adv1;

  srpt_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .advance    (adv1),
    .opcode     (pix_in.opcode),
    .write_data (pix_in.write_data),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_pix     (s1_pix)
  );

  srpt_swizzle u_swizzle (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv2),
    .s1_valid (s1_valid),
    .s1_pix   (s1_pix),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2_acc   (s2_acc)
  );

  assign ram_we = adv3 && s2_valid && s2_acc.access && s2_acc.wr;
  assign ram_re = adv3 && s2_valid && s2_acc.access && !s2_acc.wr;

  srpt_ram #(
    .ADDR_W (ADDR_BITS),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (s2_acc.addr),
    .wdata (s2_acc.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      s3_read   <= s2_acc.access && !s2_acc.wr;
      s3_last   <= s2_acc.last;
      s3_status <= s2_acc.status;
      s3_addr   <= s2_acc.addr;
    end
  end

  assign pix_out.valid        = s3_valid;
  assign pix_out.read_data    = s3_read ? ram_rdata : '0;
  assign pix_out.word_address = WORD_ADDR_W'(s3_addr);
  assign pix_out.last_pixel   = s3_last;
  assign pix_out.status       = s3_status;

  `SRPT_ASSERT_IMP(a_ram_one_access, clk, rst, ram_we, !ram_re)
  `SRPT_ASSERT_IMP(a_ignored_beat_clean, clk, rst, s3_valid && s3_status, !s3_last && s3_addr == '0)
  `SRPT_ASSERT_IMP(a_ready_when_front_free, clk, rst, !s1_valid, pix_in.ready)
  `SRPT_ASSERT_NXT(a_stall_holds_last, clk, rst, s3_valid && !pix_out.ready && s3_last, s3_valid && s3_last)

endmodule
